// ===== src/scrc_pkg.sv =====
// Shared types, constants and the CRC byte update for the skipping record CRC-32 unit.
// Used by scrc_front, scrc_fifo, scrc_back and skipping_record_crc32_unit.
package scrc_pkg;

    localparam int POS_BITS     = 20;
    localparam int SKIP_REGIONS = 3;
    localparam int CFG_IDX_BITS = 4;
    localparam int RESULT_BYTES = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_START = 32'd987654;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RESULT_ENABLE = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESULT_OFFSET = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SKIP0_OFFSET  = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SKIP2_SIZE    = 4'd7;

    typedef logic [POS_BITS-1:0] pos_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        excluded;
        logic        last;
        logic        check;
        logic [31:0] expected;
    } item_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int k = 0; k < 8; k++)
        begin
            if (c[31])
            begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/skipping_record_crc32_unit.sv =====
// Skipping record CRC-32: top level joining front end, queue and CRC back end.
// Depends on scrc_pkg, scrc_front, scrc_fifo and scrc_back.
// Throughput: one byte per clock, set by the combinational CRC byte update in the back end,
// while the queue has room and no last byte waits for an unread result to be taken.
// Reset (async, active low): config to 0, CRC to 987654, offset to 0, queue and output empty.
// No clearing pass after reset; bytes are taken from the first cycle.
module skipping_record_crc32_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        data_byte,
    input  logic                              last_byte,
    input  logic                              check,
    input  logic [31:0]                       expected_crc,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [31:0]                       crc_value,
    output logic                              mismatch,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scrc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [scrc_pkg::POS_BITS-1:0]     cfg_data
);

    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_empty;
    scrc_pkg::item_t push_item;
    scrc_pkg::item_t head;

    scrc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .check        (check),
        .expected_crc (expected_crc),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .queue_full   (queue_full),
        .push         (push),
        .push_item    (push_item)
    );

    scrc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .empty     (queue_empty),
        .head      (head)
    );

    scrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (queue_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .crc_value (crc_value),
        .mismatch  (mismatch)
    );

endmodule

// ===== src/scrc_front.sv =====
// Front end: holds configuration, tracks the byte offset and marks excluded bytes.
// Depends on scrc_pkg.
module scrc_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       data_byte,
    input  logic                             last_byte,
    input  logic                             check,
    input  logic [31:0]                      expected_crc,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scrc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [scrc_pkg::POS_BITS-1:0]     cfg_data,
    input  logic                             queue_full,
    output logic                             push,
    output scrc_pkg::item_t                  push_item
);

    logic                 result_enable_reg;
    scrc_pkg::pos_t       result_offset_reg;
    scrc_pkg::pos_t       skip_offset_reg [3];
    scrc_pkg::pos_t       skip_size_reg   [3];
    scrc_pkg::pos_t       pos_reg;
    scrc_pkg::pos_t       pos_next;
    logic                 excluded;
    logic [1:0]           region;
    logic [scrc_pkg::CFG_IDX_BITS-1:0] cfg_rel;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign push      = in_valid && in_ready;
    assign cfg_rel   = cfg_index - scrc_pkg::CFG_SKIP0_OFFSET;
    assign region    = cfg_rel[2:1];

    always_comb
    begin
        logic [scrc_pkg::POS_BITS:0] pos_x;
        logic [scrc_pkg::POS_BITS:0] start_x;
        logic [scrc_pkg::POS_BITS:0] end_x;
        pos_x   = {1'b0, pos_reg};
        start_x = {1'b0, result_offset_reg};
        end_x   = start_x + (scrc_pkg::POS_BITS+1)'(scrc_pkg::RESULT_BYTES);
        excluded = result_enable_reg && (pos_x >= start_x) && (pos_x < end_x);
        for (int r = 0; r < scrc_pkg::SKIP_REGIONS; r++)
        begin
            start_x = {1'b0, skip_offset_reg[r]};
            end_x   = start_x + {1'b0, skip_size_reg[r]};
            if ((skip_size_reg[r] != '0) && (pos_x >= start_x) && (pos_x < end_x))
            begin
                excluded = 1'b1;
            end
        end
    end

    always_comb
    begin
        push_item.data     = data_byte;
        push_item.excluded = excluded;
        push_item.last     = last_byte;
        push_item.check    = check;
        push_item.expected = expected_crc;
        pos_next           = last_byte ? '0 : pos_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_pos_reset: pos_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_enable_reg <= 1'b0;
            result_offset_reg <= '0;
            for (int r = 0; r < 3; r++)
            begin
                skip_offset_reg[r] <= '0;
                skip_size_reg[r]   <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                scrc_pkg::CFG_RESULT_ENABLE: result_enable_reg <= cfg_data[0];
                scrc_pkg::CFG_RESULT_OFFSET: result_offset_reg <= cfg_data;
                default:
                begin
                    if (cfg_index inside {[scrc_pkg::CFG_SKIP0_OFFSET:scrc_pkg::CFG_SKIP2_SIZE]})
                    begin
                        if (cfg_rel[0])
                        begin
                            skip_size_reg[region] <= cfg_data;
                        end
                        else
                        begin
                            skip_offset_reg[region] <= cfg_data;
                        end
                    end
                end
            endcase
        end
    end

endmodule

// ===== src/scrc_fifo.sv =====
// Short queue of classified bytes between the front end and the CRC back end.
// Depends on scrc_pkg.
module scrc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scrc_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output scrc_pkg::item_t head
);

    localparam int CNT_W = scrc_pkg::QUEUE_PTR_W + 1;

    scrc_pkg::item_t                     mem_reg [scrc_pkg::QUEUE_DEPTH];
    logic [scrc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [scrc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;

    assign full  = (count_reg == CNT_W'(scrc_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(scrc_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[scrc_pkg::QUEUE_PTR_W-1:0] == (wr_ptr_reg - rd_ptr_reg)))
        else $error("queue pointers disagree with count");

endmodule

// ===== src/scrc_back.sv =====
// Back end: folds queued bytes into the CRC and holds the result for the output channel.
// Depends on scrc_pkg.
module scrc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  scrc_pkg::item_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [31:0]     crc_value,
    output logic            mismatch
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic        out_valid_reg;
    logic [31:0] crc_value_reg;
    logic        mismatch_reg;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = !empty && (!head.last || slot_free);
    assign crc_next  = head.excluded ? crc_reg : scrc_pkg::crc_byte(crc_reg, head.data);

    assign out_valid = out_valid_reg;
    assign crc_value = crc_value_reg;
    assign mismatch  = mismatch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= scrc_pkg::CRC_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                crc_reg <= head.last ? scrc_pkg::CRC_START : crc_next;
            end
            if (pop && head.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            crc_value_reg <= crc_next;
            mismatch_reg  <= head.check && (crc_next != head.expected);
        end
    end

    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.last) |=> (crc_reg == scrc_pkg::CRC_START))
        else $error("CRC not restarted after last byte");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.last) |=> out_valid)
        else $error("result not presented after last byte");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head.last && out_valid && !out_ready) |=> $stable(crc_value))
        else $error("pending result overwritten by a non-final byte");

endmodule

// ===== tb/tb.sv =====
// Testbench for skipping_record_crc32_unit: byte driver, result monitor and a CRC predictor.
// Needs scrc_pkg and the unit RTL; runs directed records and random phases with fresh
// register settings.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scrc_pkg::*;

    localparam int REG_COUNT      = CFG_SKIP2_SIZE + 1;
    localparam int IDX_TOP        = (1 << CFG_IDX_BITS) - 1;
    localparam int SETTLE_CYCLES  = 4;
    localparam int QUEUE_CAP      = 4096;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int PHASES         = 6;
    localparam int PHASE_BYTES    = 110;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        chk;
        logic [31:0] expected;
    } byte_xact_t;

    typedef struct packed {
        logic [31:0] crc;
        logic        mismatch;
    } crc_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [7:0]              data_byte = '0;
    logic                    last_byte = 1'b0;
    logic                    check = 1'b0;
    logic [31:0]             expected_crc = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [31:0]             crc_value;
    logic                    mismatch;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    pos_t                    cfg_data = '0;

    // register copy used for prediction
    logic res_en = 1'b0;
    pos_t res_off = '0;
    pos_t skip_at [SKIP_REGIONS];
    pos_t skip_len [SKIP_REGIONS];

    logic [31:0] run_crc = CRC_START;
    pos_t        run_pos = '0;

    byte_xact_t  pending [$];
    crc_result_t results_due [$];
    byte_xact_t  tx_cur;
    crc_result_t rx_want;
    pos_t        reg_plan [REG_COUNT];

    int     tx_wait = 0;
    int     rx_wait = 0;
    int     tx_gap_max = 0;
    int     rx_gap_max = 0;
    longint bytes_queued = 0;
    longint bytes_taken = 0;
    int     err_cnt = 0;
    logic   rx_hold = 1'b0;
    bit     squeeze_go = 1'b0;

    skipping_record_crc32_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .check        (check),
        .expected_crc (expected_crc),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .crc_value    (crc_value),
        .mismatch     (mismatch),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] crc_shift_byte(input logic [31:0] c, input logic [7:0] b);
        logic fb;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[31] ^ b[k];
            c = {c[30:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic bit in_span(input pos_t p, input pos_t start, input pos_t len);
        logic [POS_BITS:0] span_end;
        span_end = {1'b0, start} + {1'b0, len};
        return (p >= start) && ({1'b0, p} < span_end);
    endfunction

    function automatic bit offset_skipped(input pos_t p);
        bit hit;
        hit = res_en && in_span(p, res_off, pos_t'(RESULT_BYTES));
        for (int r = 0; r < SKIP_REGIONS; r++)
        begin
            if (skip_len[r] != '0 && in_span(p, skip_at[r], skip_len[r]))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx, input pos_t val);
        int r;
        r = (int'(idx) - int'(CFG_SKIP0_OFFSET)) / 2;
        if (idx == CFG_RESULT_ENABLE)
        begin
            res_en = val[0];
        end
        else if (idx == CFG_RESULT_OFFSET)
        begin
            res_off = val;
        end
        else if (idx >= CFG_SKIP0_OFFSET && idx <= CFG_SKIP2_SIZE)
        begin
            if (((int'(idx) - int'(CFG_SKIP0_OFFSET)) % 2) == 0)
            begin
                skip_at[r] = val;
            end
            else
            begin
                skip_len[r] = val;
            end
        end
    endfunction

    function automatic void track_byte(input byte_xact_t x);
        crc_result_t res;
        if (!offset_skipped(run_pos))
        begin
            run_crc = crc_shift_byte(run_crc, x.data);
        end
        run_pos = run_pos + 1'b1;
        if (x.last)
        begin
            res.crc = run_crc;
            res.mismatch = x.chk && (run_crc != x.expected);
            results_due.push_back(res);
            run_crc = CRC_START;
            run_pos = '0;
        end
    endfunction

    function automatic pos_t pick_offset();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return pos_t'($urandom);
            default: return pos_t'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic pos_t pick_size();
        case ($urandom_range(0, 15))
            0, 1, 2: return '0;
            3: return '1;
            4: return pos_t'($urandom);
            default: return pos_t'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input pos_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    task automatic load_plan();
        for (int i = 0; i < REG_COUNT; i++)
        begin
            write_reg(CFG_IDX_BITS'(i), reg_plan[i]);
        end
        write_reg(CFG_IDX_BITS'($urandom_range(REG_COUNT, IDX_TOP)), pos_t'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic push_record(input longint len, input bit chk, input bit good, input int fill);
        byte_xact_t  x;
        logic [31:0] c;
        pos_t        p;
        c = CRC_START;
        p = '0;
        for (longint i = 0; i < len; i++)
        begin
            while (pending.size() >= QUEUE_CAP)
            begin
                @(posedge clk);
            end
            x.data = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (!offset_skipped(p))
            begin
                c = crc_shift_byte(c, x.data);
            end
            p = p + 1'b1;
            x.last = (i == len - 1);
            x.chk = 1'($urandom);
            x.expected = $urandom;
            if (x.last)
            begin
                x.chk = chk;
                if (chk && good)
                begin
                    x.expected = c;
                end
                else if (chk && $urandom_range(0, 1) == 1)
                begin
                    x.expected = c ^ (32'd1 << $urandom_range(0, 31));
                end
            end
            pending.push_back(x);
            bytes_queued++;
        end
    endtask

    // wait until every byte is taken and every result is back, then drain the pipeline
    task automatic settle();
        while (bytes_taken != bytes_queued || results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_byte(tx_cur);
                bytes_taken++;
                tx_wait = $urandom_range(0, tx_gap_max);
            end
            if (!in_valid || in_ready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    tx_cur = pending.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= tx_cur.data;
                    last_byte <= tx_cur.last;
                    check <= tx_cur.chk;
                    expected_crc <= tx_cur.expected;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual crc %h mismatch %b",
                             $time, crc_value, mismatch);
                    err_cnt++;
                end
                else
                begin
                    rx_want = results_due.pop_front();
                    if (crc_value !== rx_want.crc)
                    begin
                        $display("%0t: crc_value expected %h actual %h",
                                 $time, rx_want.crc, crc_value);
                        err_cnt++;
                    end
                    if (mismatch !== rx_want.mismatch)
                    begin
                        $display("%0t: mismatch expected %b actual %b",
                                 $time, rx_want.mismatch, mismatch);
                        err_cnt++;
                    end
                end
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            if (rx_hold)
            begin
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // hold the result side off while bytes keep coming
    initial
    begin
        wait (squeeze_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        longint phase_bytes;
        int     len;
        for (int r = 0; r < SKIP_REGIONS; r++)
        begin
            skip_at[r] = '0;
            skip_len[r] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: nothing excluded
        push_record(3, 1'b0, 1'b0, 0);
        push_record(1, 1'b1, 1'b0, 255);
        settle();

        // result word, overlapping regions, region past the top offset
        reg_plan[CFG_RESULT_ENABLE] = pos_t'(1);
        reg_plan[CFG_RESULT_OFFSET] = pos_t'(2);
        reg_plan[CFG_SKIP0_OFFSET] = pos_t'(5);
        reg_plan[CFG_SKIP0_OFFSET + 1] = pos_t'(2);
        reg_plan[CFG_SKIP0_OFFSET + 2] = pos_t'(6);
        reg_plan[CFG_SKIP0_OFFSET + 3] = pos_t'(3);
        reg_plan[CFG_SKIP0_OFFSET + 4] = '1;
        reg_plan[CFG_SKIP2_SIZE] = '1;
        write_reg(CFG_IDX_BITS'(IDX_TOP), '1);
        load_plan();
        push_record(8, 1'b1, 1'b1, -1);
        push_record(1, 1'b1, 1'b0, 255);
        push_record(4, 1'b1, 1'b0, 0);
        settle();

        // whole record excluded; wide value clears the enable bit
        reg_plan[CFG_RESULT_ENABLE] = pos_t'(20'hFFFFE);
        reg_plan[CFG_SKIP0_OFFSET] = '0;
        reg_plan[CFG_SKIP0_OFFSET + 1] = '1;
        load_plan();
        push_record(3, 1'b1, 1'b1, -1);
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            reg_plan[CFG_RESULT_ENABLE] = pos_t'($urandom);
            reg_plan[CFG_RESULT_OFFSET] = pick_offset();
            for (int r = 0; r < SKIP_REGIONS; r++)
            begin
                reg_plan[CFG_SKIP0_OFFSET + 2 * r] = pick_offset();
                reg_plan[CFG_SKIP0_OFFSET + 2 * r + 1] = pick_size();
            end
            load_plan();
            if (ph == 0)
            begin
                tx_gap_max = 0;
                rx_gap_max = 0;
            end
            else if (ph == 1)
            begin
                tx_gap_max = 5;
                rx_gap_max = 5;
            end
            else
            begin
                tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
                rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 40);
                push_record(len, 1'($urandom), 1'($urandom), -1);
                phase_bytes += len;
            end
            settle();
        end

        // short records back to back while the result side is held
        tx_gap_max = 0;
        rx_gap_max = 0;
        phase_bytes = 0;
        while (phase_bytes < 120)
        begin
            len = $urandom_range(1, 3);
            push_record(len, 1'($urandom), 1'($urandom), -1);
            phase_bytes += len;
        end
        squeeze_go = 1'b1;
        settle();

        if (err_cnt == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
